// ----- sv/fbfl_pkg.sv -----
// Shared codes and types for the fixed block free list allocator.
package fbfl_pkg;

	// Operation carried by one request
	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	// Result status reported with each response
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_OVERFREE = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	// Block count that reset selects before any configuration write
	localparam int unsigned RESET_BLOCK_COUNT = 256;

endpackage

// ----- sv/fbfl_succ_ram.sv -----
// Successor memory of the free list, with the entry-zero end mark held apart.
module fbfl_succ_ram #(
	parameter int unsigned MAX_BLOCKS = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               clear,
	input  logic                               we,
	input  logic [$clog2(MAX_BLOCKS)-1:0]      waddr,
	input  logic [$clog2(MAX_BLOCKS+1)-1:0]    wdata,
	input  logic                               re,
	input  logic [$clog2(MAX_BLOCKS)-1:0]      raddr,
	output logic [$clog2(MAX_BLOCKS+1)-1:0]    rdata
);

	localparam int unsigned IW = $clog2(MAX_BLOCKS);
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] END_MARK = CW'(MAX_BLOCKS);

	logic [CW-1:0] mem [MAX_BLOCKS];
	logic [CW-1:0] rdata_q;
	logic          e0_end_q;
	logic          e0_hit_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// Track entry zero holding the end mark until it is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e0_end_q <= 1'b1;
			e0_hit_q <= 1'b0;
		end else begin
			if (clear) begin
				e0_end_q <= 1'b1;
			end else if (we && waddr == IW'(0)) begin
				e0_end_q <= 1'b0;
			end
			if (re) begin
				e0_hit_q <= e0_end_q && (raddr == IW'(0));
			end
		end
	end

	assign rdata = e0_hit_q ? END_MARK : rdata_q;

endmodule

// ----- sv/fixed_block_free_list_allocator.sv -----
// Top level of the fixed block free list allocator.
//
// Hands out and takes back block indices from a pool of block_count slots
// through a LIFO free list that is carved lazily, so no clearing pass runs
// after reset or after a block_count write. A request is taken when start is
// high and busy is low; busy then stays high for one cycle and the response
// appears on the next cycle for exactly one cycle, marked by done, and a new
// request may be started in the same cycle that done is shown. This pace is
// set by the successor memory: the head slot's successor is read on the
// accepting edge and the list is updated on the next. The receiver cannot
// stall; done must be consumed when it appears.
// A block_count write (cfg_valid with cfg_ready) restarts the pool; a value
// of zero acts as one and a value above MAX_BLOCKS acts as MAX_BLOCKS.
module fixed_block_free_list_allocator
	import fbfl_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              op,
	input  logic [$clog2(MAX_BLOCKS)-1:0]     block_index,
	output logic                              done,
	output logic [$clog2(MAX_BLOCKS)-1:0]     granted_index,
	output logic [1:0]                        status,
	output logic [$clog2(MAX_BLOCKS+1)-1:0]   free_count,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [$clog2(MAX_BLOCKS+1)-1:0]   block_count
);

	localparam int unsigned IW = $clog2(MAX_BLOCKS);
	localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] END_MARK = CW'(MAX_BLOCKS);
	localparam int unsigned RST_CNT =
		(RESET_BLOCK_COUNT > MAX_BLOCKS) ? MAX_BLOCKS : RESET_BLOCK_COUNT;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t        state_q;
	op_t           op_s1;
	logic [IW-1:0] idx_s1;
	logic [CW-1:0] head_q;
	logic [CW-1:0] free_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [IW-1:0] granted_q;
	status_t       status_q;

	logic          accept;
	logic          cfg_wr;
	logic [CW-1:0] cfg_eff;
	logic [CW-1:0] nxt;
	logic [CW-1:0] carve;
	logic [CW-1:0] head_d;
	logic [CW-1:0] free_d;
	logic [IW-1:0] grant_d;
	status_t       status_d;
	logic          upd_we;
	logic [IW-1:0] upd_waddr;
	logic [CW-1:0] upd_wdata;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q == S_EXEC);
	assign cfg_ready = (state_q == S_IDLE);
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Clamp the written block count into 1..MAX_BLOCKS
	always_comb begin
		if (block_count == '0) begin
			cfg_eff = CW'(1);
		end else if (block_count > END_MARK) begin
			cfg_eff = END_MARK;
		end else begin
			cfg_eff = block_count;
		end
	end

	fbfl_succ_ram #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_succ_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (cfg_wr),
		.we    (upd_we && busy),
		.waddr (upd_waddr),
		.wdata (upd_wdata),
		.re    (accept),
		.raddr (head_q[IW-1:0]),
		.rdata (nxt)
	);

	// Pop or push the list for the request held in stage one
	always_comb begin
		head_d    = head_q;
		free_d    = free_q;
		grant_d   = '0;
		status_d  = ST_OK;
		upd_we    = 1'b0;
		upd_waddr = idx_s1;
		upd_wdata = head_q;
		carve     = head_q + CW'(1);
		if (op_s1 == OP_ALLOC) begin
			if (free_q == '0 || head_q >= END_MARK) begin
				status_d = ST_EMPTY;
			end else begin
				grant_d = head_q[IW-1:0];
				free_d  = free_q - CW'(1);
				if (nxt >= END_MARK && free_d != '0) begin
					// List ran out with slots left: carve the next one
					if (carve < cnt_q) begin
						upd_we    = 1'b1;
						upd_waddr = carve[IW-1:0];
						upd_wdata = END_MARK;
						head_d    = carve;
					end else begin
						head_d = END_MARK;
					end
				end else begin
					head_d = (nxt >= END_MARK) ? END_MARK : nxt;
				end
			end
		end else begin
			if (CW'(idx_s1) >= cnt_q) begin
				status_d = ST_RANGE;
			end else if (free_q >= cnt_q) begin
				status_d = ST_OVERFREE;
			end else begin
				upd_we = 1'b1;
				head_d = CW'(idx_s1);
				free_d = free_q + CW'(1);
			end
		end
	end

	// Hold the request for the update cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op_t'(op);
			idx_s1 <= block_index;
		end
	end

	// Sequence one transaction and hold list state and the response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			head_q    <= '0;
			free_q    <= CW'(RST_CNT);
			cnt_q     <= CW'(RST_CNT);
			done_q    <= 1'b0;
			granted_q <= '0;
			status_q  <= ST_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_wr) begin
						cnt_q  <= cfg_eff;
						free_q <= cfg_eff;
						head_q <= '0;
					end
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					head_q    <= head_d;
					free_q    <= free_d;
					granted_q <= grant_d;
					status_q  <= status_d;
					done_q    <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign granted_index = granted_q;
	assign status        = status_q;
	assign free_count    = free_q;

	// A response follows exactly one update cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("response without a preceding update cycle");

	// Free blocks never exceed the pool size
	assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= cnt_q)
		else $error("free count above block count");

	// A rejected call leaves the free count untouched
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q != ST_OK) |-> (free_q == $past(free_q)))
		else $error("rejected call changed the free count");

	// A rejected call of either kind grants index zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && status_q != ST_OK) |-> (granted_q == '0))
		else $error("rejected call granted a block");

endmodule

// ----- bench/fixed_block_free_list_allocator_test.sv -----
// Self-checking testbench for the fixed block free list allocator.
`timescale 1ns / 100ps

module fixed_block_free_list_allocator_test;
	import fbfl_pkg::*;

	localparam int unsigned MAX_BLOCKS = 256;
	localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
	localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam logic [CNT_W-1:0] END_MARK = CNT_W'(MAX_BLOCKS);
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned PHASES = 12;
	localparam int unsigned ITEMS_PER_PHASE = 131;

	typedef struct packed {
		logic [IDX_W-1:0] granted;
		status_t          status;
		logic [CNT_W-1:0] free_cnt;
	} response_t;

	typedef struct {
		op_t              op;
		logic [IDX_W-1:0] index;
		response_t        rsp;
	} txn_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic             op = OP_ALLOC;
	logic [IDX_W-1:0] block_index = '0;
	logic             done;
	logic [IDX_W-1:0] granted_index;
	logic [1:0]       status;
	logic [CNT_W-1:0] free_count;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] block_count = CNT_W'(RESET_BLOCK_COUNT);

	fixed_block_free_list_allocator #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.block_index  (block_index),
		.done         (done),
		.granted_index(granted_index),
		.status       (status),
		.free_count   (free_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.block_count  (block_count)
	);

	// Shadow copy of the pool: successor links, head, free count, clamped size
	logic [CNT_W-1:0] next_slot [MAX_BLOCKS];
	logic [CNT_W-1:0] head_slot;
	logic [CNT_W-1:0] free_left;
	logic [CNT_W-1:0] pool_size;

	txn_t             request_q[$];
	response_t        expected_responses[$];
	logic [IDX_W-1:0] held_blocks[$];
	txn_t             accepted_txn;
	response_t        due_rsp;
	int unsigned      sender_idle_pct = 31;
	int unsigned      mismatch_total = 0;
	int unsigned      cycle_count = 0;

	// Rebuild the pool as a reset or a block_count write does
	function automatic void pool_restart(input logic [CNT_W-1:0] value);
		if (value == 0)
			pool_size = CNT_W'(1);
		else if (value > END_MARK)
			pool_size = END_MARK;
		else
			pool_size = value;
		for (int i = 0; i < MAX_BLOCKS; i++)
			next_slot[i] = '0;
		next_slot[0] = END_MARK;
		head_slot = '0;
		free_left = pool_size;
	endfunction

	// Apply one request to the shadow pool and return the response it yields
	function automatic response_t predict_pool_response(input op_t kind,
			input logic [IDX_W-1:0] idx);
		response_t rsp;
		logic [CNT_W-1:0] slot;
		logic [CNT_W-1:0] nxt;
		logic [CNT_W-1:0] carve;
		rsp.granted = '0;
		rsp.status = ST_OK;
		if (kind == OP_ALLOC) begin
			if (free_left == 0 || head_slot >= END_MARK) begin
				rsp.status = ST_EMPTY;
			end else begin
				slot = head_slot;
				nxt = next_slot[slot[IDX_W-1:0]];
				rsp.granted = slot[IDX_W-1:0];
				free_left = free_left - 1'b1;
				if (nxt >= END_MARK && free_left > 0) begin
					// list ran out: carve the slot after the one handed out
					carve = slot + 1'b1;
					if (carve < pool_size) begin
						next_slot[carve[IDX_W-1:0]] = END_MARK;
						head_slot = carve;
					end else begin
						head_slot = END_MARK;
					end
				end else begin
					head_slot = (nxt >= END_MARK) ? END_MARK : nxt;
				end
			end
		end else begin
			if (CNT_W'(idx) >= pool_size) begin
				rsp.status = ST_RANGE;
			end else if (free_left >= pool_size) begin
				rsp.status = ST_OVERFREE;
			end else begin
				next_slot[idx] = head_slot;
				head_slot = CNT_W'(idx);
				free_left = free_left + 1'b1;
			end
		end
		rsp.free_cnt = free_left;
		return rsp;
	endfunction

	// Predict a request, track which blocks are out, and queue it for the driver
	task automatic queue_request(input op_t kind, input logic [IDX_W-1:0] idx);
		txn_t t;
		bit found;
		t.op = kind;
		t.index = idx;
		t.rsp = predict_pool_response(kind, idx);
		found = 1'b0;
		if (t.rsp.status == ST_OK) begin
			if (kind == OP_ALLOC) begin
				held_blocks.push_back(t.rsp.granted);
			end else begin
				for (int i = 0; i < held_blocks.size() && !found; i++) begin
					if (held_blocks[i] == idx) begin
						held_blocks.delete(i);
						found = 1'b1;
					end
				end
			end
		end
		request_q.push_back(t);
	endtask

	// Hold until every queued transaction is answered, then let the block settle
	task automatic wait_for_idle();
		while (request_q.size() != 0 || expected_responses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write block_count over the config channel; call only while idle
	task automatic write_block_count(input logic [CNT_W-1:0] value);
		cfg_valid <= 1'b1;
		block_count <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		pool_restart(value);
		held_blocks.delete();
	endtask

	// Mostly legal alloc/free traffic with drifting bias, plus a little noise
	task automatic queue_random_phase(input int unsigned items);
		int unsigned alloc_pct;
		int unsigned roll;
		int unsigned pick;
		alloc_pct = 50;
		for (int n = 0; n < items; n++) begin
			if (n % 24 == 0) begin
				case ($urandom_range(2))
					0: alloc_pct = 85;
					1: alloc_pct = 50;
					default: alloc_pct = 20;
				endcase
			end
			roll = $urandom_range(99);
			if (roll < 88) begin
				if (held_blocks.size() == 0 || $urandom_range(99) < alloc_pct) begin
					queue_request(OP_ALLOC, IDX_W'($urandom));
				end else begin
					pick = $urandom_range(held_blocks.size() - 1);
					queue_request(OP_FREE, held_blocks[pick]);
				end
			end else if (roll < 99) begin
				// rejected frees: past the pool end, or with nothing handed out; else an allocate
				if (pool_size < END_MARK)
					queue_request(OP_FREE, IDX_W'($urandom_range(MAX_BLOCKS - 1, pool_size)));
				else if (free_left == pool_size)
					queue_request(OP_FREE, IDX_W'($urandom));
				else
					queue_request(OP_ALLOC, IDX_W'($urandom));
			end else begin
				// any index at all, repeated frees included
				queue_request(OP_FREE, IDX_W'($urandom));
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Driver: present the oldest pending request, idling at random between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			op <= OP_ALLOC;
			block_index <= '0;
		end else begin
			if (start && !busy) begin
				accepted_txn = request_q.pop_front();
				expected_responses.push_back(accepted_txn.rsp);
			end
			// hold a request the block has not taken yet
			if (!(start && busy)) begin
				if (request_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					start <= 1'b1;
					op <= request_q[0].op;
					block_index <= request_q[0].index;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each strobed response against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done !== 1'b0) begin
			if (expected_responses.size() == 0) begin
				$error("unexpected transaction: granted_index %0d status %0d free_count %0d",
					granted_index, status, free_count);
				mismatch_total++;
			end else begin
				due_rsp = expected_responses.pop_front();
				if (granted_index !== due_rsp.granted) begin
					$error("granted_index: expected %0d, actual %0d", due_rsp.granted,
						granted_index);
					mismatch_total++;
				end
				if (status !== due_rsp.status) begin
					$error("status: expected %0d, actual %0d", due_rsp.status, status);
					mismatch_total++;
				end
				if (free_count !== due_rsp.free_cnt) begin
					$error("free_count: expected %0d, actual %0d", due_rsp.free_cnt,
						free_count);
					mismatch_total++;
				end
			end
		end
	end

	// Stimulus: directed corner cases, then randomized phases under several pool sizes
	initial begin
		logic [CNT_W-1:0] phase_sizes [PHASES];
		phase_sizes = '{9'd4, 9'd1, 9'd511, 9'd2, 9'd16, 9'd0, 9'd257, 9'd7,
			9'd256, 9'd0, 9'd0, 9'd32};
		phase_sizes[9] = CNT_W'($urandom_range(48, 3));
		phase_sizes[10] = CNT_W'($urandom_range(300, 1));
		pool_restart(CNT_W'(RESET_BLOCK_COUNT));
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// full pool after reset: over-free, carve, reuse from the list
		queue_request(OP_FREE, 8'd255);
		queue_request(OP_ALLOC, 8'd0);
		queue_request(OP_ALLOC, 8'd255);
		queue_request(OP_FREE, 8'd0);
		queue_request(OP_ALLOC, 8'd0);
		queue_request(OP_FREE, 8'd1);
		queue_request(OP_FREE, 8'd0);
		wait_for_idle();

		// zero acts as a one-block pool: range, empty, over-free
		write_block_count(9'd0);
		queue_request(OP_FREE, 8'd1);
		queue_request(OP_FREE, 8'd0);
		queue_request(OP_ALLOC, 8'd0);
		queue_request(OP_ALLOC, 8'd0);
		queue_request(OP_FREE, 8'd255);
		queue_request(OP_FREE, 8'd0);
		wait_for_idle();

		// oversized count clamps to the full pool
		write_block_count(9'd511);
		queue_request(OP_ALLOC, 8'd255);
		queue_request(OP_FREE, 8'd0);
		queue_request(OP_FREE, 8'd0);
		wait_for_idle();

		// two blocks: drain, then free one block twice to corrupt the list
		write_block_count(9'd2);
		queue_request(OP_ALLOC, 8'd0);
		queue_request(OP_ALLOC, 8'd0);
		queue_request(OP_ALLOC, 8'd0);
		queue_request(OP_FREE, 8'd1);
		queue_request(OP_FREE, 8'd1);
		queue_request(OP_ALLOC, 8'd0);
		queue_request(OP_ALLOC, 8'd0);
		wait_for_idle();

		for (int p = 0; p < PHASES; p++) begin
			sender_idle_pct = (p < 4) ? 31 : (p < 8) ? 70 : 0;
			write_block_count(phase_sizes[p]);
			queue_random_phase(ITEMS_PER_PHASE);
			wait_for_idle();
		end

		if (mismatch_total == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
sv/fbfl_pkg.sv
sv/fbfl_succ_ram.sv
sv/fixed_block_free_list_allocator.sv
bench/fixed_block_free_list_allocator_test.sv
